// ===== sv/hsdf_pkg.sv =====
`default_nettype none
package hsdf_pkg;
  localparam int MAX_KEPT_DEF   = 16;
  localparam int COORD_BITS_DEF = 11;
  localparam int SLOPE_W        = 37;
  localparam int ICPT_W         = 64;
  localparam int CFG_AW         = 4;

  localparam logic [SLOPE_W-1:0] VERTICAL_SLOPE = 37'd65536000000;

  localparam logic [CFG_AW-1:0] REG_MIN_ABS   = 4'h0;
  localparam logic [CFG_AW-1:0] REG_MIN_ANGLE = 4'h4;
  localparam logic [CFG_AW-1:0] REG_DUP_SLOPE = 4'h8;
  localparam logic [CFG_AW-1:0] REG_DUP_ICPT  = 4'hC;

  typedef enum logic [2:0] {
    VERDICT_KEPT      = 3'd0,
    VERDICT_FLAT      = 3'd1,
    VERDICT_ANGLE     = 3'd2,
    VERDICT_DUPLICATE = 3'd3,
    VERDICT_FULL      = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_ICPT,
    FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SCAN,
    BS_DECIDE,
    BS_OUT
  } back_state_t;

  // Thresholds held by the register file and used by both halves.
  typedef struct packed {
    logic [19:0] min_abs_slope;
    logic [19:0] min_angle_slope;
    logic [19:0] dup_slope_tol;
    logic [31:0] dup_icpt_tol;
  } cfg_t;
endpackage
`default_nettype wire

// ===== sv/hsdf_ram.sv =====
`default_nettype none
module hsdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/hsdf_front.sv =====
`default_nettype none
// Accepts a segment, divides dy*65536 by dx bit by bit, forms the intercept
// and classifies the slope against the flat and angle thresholds.
module hsdf_front #(
  parameter int COORD_BITS = hsdf_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hsdf_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [COORD_BITS-1:0]         in_x_start,
  input  wire logic [COORD_BITS-1:0]         in_y_start,
  input  wire logic [COORD_BITS-1:0]         in_x_end,
  input  wire logic [COORD_BITS-1:0]         in_y_end,
  input  wire logic                          in_frame_start,
  output logic                               q_push,
  input  wire logic                          q_full,
  output logic [hsdf_pkg::SLOPE_W-1:0]       q_slope,
  output logic [hsdf_pkg::ICPT_W-1:0]        q_icpt,
  output logic [2:0]                         q_verdict,
  output logic                               q_frame
);
  import hsdf_pkg::*;

  localparam int NUM_W = COORD_BITS + 16;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int PW    = SLOPE_W + COORD_BITS + 1;

  front_state_t state_r, state_nxt;
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic [COORD_BITS-1:0] den_r, den_nxt;
  logic [COORD_BITS:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  vert_r, vert_nxt;
  logic                  frame_r, frame_nxt;
  logic [COORD_BITS-1:0] x1_r, x1_nxt;
  logic [COORD_BITS-1:0] y1_r, y1_nxt;
  logic [SLOPE_W-1:0]    slope_r, slope_nxt;
  logic [ICPT_W-1:0]     icpt_r, icpt_nxt;
  logic [2:0]            verd_r, verd_nxt;

  logic                  accept;
  logic [COORD_BITS:0]   dx_s, dy_s;
  logic [COORD_BITS:0]   rem_sh;
  logic                  fits;
  logic [SLOPE_W-1:0]    slope_c, mag_c;
  logic signed [PW-1:0]  prod_c;

  assign accept = in_valid && !in_stall;
  assign dx_s   = {1'b0, in_x_end} - {1'b0, in_x_start};
  assign dy_s   = {1'b0, in_y_end} - {1'b0, in_y_start};
  assign rem_sh = {rem_r[COORD_BITS-1:0], num_r[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_comb begin
    slope_c = SLOPE_W'(num_r);
    if (vert_r) begin
      slope_c = VERTICAL_SLOPE;
    end else if (neg_r) begin
      slope_c = -SLOPE_W'(num_r);
    end
    mag_c = vert_r ? VERTICAL_SLOPE : SLOPE_W'(num_r);
  end

  // The product needs the full slope width plus the coordinate width.
  assign prod_c = PW'($signed(slope_c)) * PW'($signed({1'b0, x1_r}));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: if (accept) state_nxt = FS_DIV;
      FS_DIV:  if (vert_r || cnt_r == CNT_W'(NUM_W - 1)) state_nxt = FS_ICPT;
      FS_ICPT: state_nxt = FS_PUSH;
      FS_PUSH: if (!q_full) state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    vert_nxt  = vert_r;
    frame_nxt = frame_r;
    x1_nxt    = x1_r;
    y1_nxt    = y1_r;
    slope_nxt = slope_r;
    icpt_nxt  = icpt_r;
    verd_nxt  = verd_r;
    case (state_r)
      FS_IDLE: begin
        if (accept) begin
          den_nxt   = dx_s[COORD_BITS] ? COORD_BITS'(-dx_s) : dx_s[COORD_BITS-1:0];
          num_nxt   = {(dy_s[COORD_BITS] ? COORD_BITS'(-dy_s) : dy_s[COORD_BITS-1:0]),
                       16'd0};
          neg_nxt   = dx_s[COORD_BITS] ^ dy_s[COORD_BITS];
          vert_nxt  = (dx_s == '0);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          frame_nxt = in_frame_start;
          x1_nxt    = in_x_start;
          y1_nxt    = in_y_start;
        end
      end
      FS_DIV: begin
        // Restoring division, one quotient bit per cycle into num_r.
        rem_nxt = fits ? rem_sh - {1'b0, den_r} : rem_sh;
        num_nxt = {num_r[NUM_W-2:0], fits};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      FS_ICPT: begin
        slope_nxt = slope_c;
        icpt_nxt  = (ICPT_W'(y1_r) << 16) - ICPT_W'(prod_c);
        if (mag_c < SLOPE_W'(cfg.min_abs_slope)) begin
          verd_nxt = VERDICT_FLAT;
        end else if (mag_c < SLOPE_W'(cfg.min_angle_slope)) begin
          verd_nxt = VERDICT_ANGLE;
        end else begin
          verd_nxt = VERDICT_KEPT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    vert_r  <= vert_nxt;
    frame_r <= frame_nxt;
    x1_r    <= x1_nxt;
    y1_r    <= y1_nxt;
    slope_r <= slope_nxt;
    icpt_r  <= icpt_nxt;
    verd_r  <= verd_nxt;
  end

  assign in_stall  = (state_r != FS_IDLE);
  assign q_push    = (state_r == FS_PUSH) && !q_full;
  assign q_slope   = slope_r;
  assign q_icpt    = icpt_r;
  assign q_verdict = verd_r;
  assign q_frame   = frame_r;
endmodule
`default_nettype wire

// ===== sv/hsdf_queue.sv =====
`default_nettype none
module hsdf_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] slot_r [2];
  logic [1:0]       cnt_r, cnt_nxt;
  logic             wp_r, rp_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign rdata     = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
    end
    if (push) slot_r[wp_r] <= wdata;
  end
endmodule
`default_nettype wire

// ===== sv/hsdf_back.sv =====
`default_nettype none
// Scans the kept table for a duplicate, appends or rejects, and holds
// the verdict in the output register until taken.
module hsdf_back #(
  parameter int MAX_KEPT = hsdf_pkg::MAX_KEPT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire hsdf_pkg::cfg_t               cfg,
  input  wire logic                         q_valid,
  output logic                              q_pop,
  input  wire logic [hsdf_pkg::SLOPE_W-1:0] q_slope,
  input  wire logic [hsdf_pkg::ICPT_W-1:0]  q_icpt,
  input  wire logic [2:0]                   q_verdict,
  input  wire logic                         q_frame,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_kept,
  output logic [2:0]                        out_verdict,
  output logic [hsdf_pkg::SLOPE_W-1:0]      out_slope_q16,
  output logic [4:0]                        out_kept_count
);
  import hsdf_pkg::*;

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW = $clog2(MAX_KEPT + 1);

  back_state_t state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic               dup_r, dup_nxt;
  logic [SLOPE_W-1:0] slope_r, slope_nxt;
  logic [ICPT_W-1:0]  icpt_r, icpt_nxt;
  logic [2:0]         verd_r, verd_nxt;
  logic               ov_r, ov_nxt;

  logic               we;
  logic [AW-1:0]      raddr;
  logic [47:0]        rd_slope;
  logic [ICPT_W-1:0]  rd_icpt;
  logic [47:0]        ds;
  logic [ICPT_W-1:0]  di;
  logic               hit;

  assign raddr = AW'(idx_r);
  assign we    = (state_r == BS_DECIDE) && (verd_nxt == VERDICT_KEPT);

  hsdf_ram #(.WIDTH(48), .DEPTH(MAX_KEPT)) u_slope_ram (
    .clk(clk), .we(we), .waddr(AW'(count_r)), .wdata(48'($signed(slope_r))),
    .raddr(raddr), .rdata(rd_slope)
  );
  hsdf_ram #(.WIDTH(ICPT_W), .DEPTH(MAX_KEPT)) u_icpt_ram (
    .clk(clk), .we(we), .waddr(AW'(count_r)), .wdata(icpt_r),
    .raddr(raddr), .rdata(rd_icpt)
  );

  always_comb begin
    ds  = 48'($signed(slope_r)) - rd_slope;
    di  = icpt_r - rd_icpt;
    if (ds[47]) ds = -ds;
    if (di[ICPT_W-1]) di = -di;
    hit = (ds < 48'(cfg.dup_slope_tol)) && (di < ICPT_W'(cfg.dup_icpt_tol));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: if (q_valid) begin
        state_nxt = (q_verdict == VERDICT_KEPT) ? BS_SCAN : BS_OUT;
      end
      BS_SCAN: if (dup_nxt || (idx_r == count_r && !rd_ok_r) ||
                   (rd_ok_r && idx_r == count_r)) state_nxt = BS_DECIDE;
      BS_DECIDE: state_nxt = BS_OUT;
      BS_OUT: if (!out_stall) state_nxt = BS_IDLE;
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    rd_ok_nxt = 1'b0;
    dup_nxt   = dup_r;
    slope_nxt = slope_r;
    icpt_nxt  = icpt_r;
    verd_nxt  = verd_r;
    ov_nxt    = 1'b0;
    q_pop     = 1'b0;
    case (state_r)
      BS_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          slope_nxt = q_slope;
          icpt_nxt  = q_icpt;
          verd_nxt  = q_verdict;
          dup_nxt   = 1'b0;
          idx_nxt   = '0;
          if (q_frame) count_nxt = '0;
          ov_nxt    = (q_verdict != VERDICT_KEPT);
        end
      end
      BS_SCAN: begin
        // Read data of entry idx_r-1 is present when rd_ok_r is set.
        if (rd_ok_r && hit) dup_nxt = 1'b1;
        if (idx_r != count_r) begin
          idx_nxt   = idx_r + CW'(1);
          rd_ok_nxt = 1'b1;
        end
      end
      BS_DECIDE: begin
        if (dup_r) begin
          verd_nxt = VERDICT_DUPLICATE;
        end else if (count_r == CW'(MAX_KEPT)) begin
          verd_nxt = VERDICT_FULL;
        end else begin
          verd_nxt  = VERDICT_KEPT;
          count_nxt = count_r + CW'(1);
        end
        ov_nxt = 1'b1;
      end
      BS_OUT: ov_nxt = out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
    idx_r   <= idx_nxt;
    dup_r   <= dup_nxt;
    slope_r <= slope_nxt;
    icpt_r  <= icpt_nxt;
    verd_r  <= verd_nxt;
  end

  assign out_valid      = ov_r;
  assign out_kept       = (verd_r == VERDICT_KEPT);
  assign out_verdict    = verd_r;
  assign out_slope_q16  = slope_r;
  assign out_kept_count = 5'(count_r);
endmodule
`default_nettype wire

// ===== sv/hough_segment_dedup_filter.sv =====
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_stall   | x_start y_start x_end y_end frame_start
// out     | output    | out_valid/out_stall | kept verdict slope_q16 kept_count
// cfg     | input     | APB psel/penable    | four threshold registers
//
// The front stalls its input from one accepted item until it has pushed the result (one
// quotient bit per cycle of the slope divider); a vertical segment skips the divider.
// The back scans the kept table for a candidate; a rejected one skips the scan.
// Front and back overlap through a two-entry queue.
// Reset is synchronous; kept table contents are undefined until written.
// A stalled output holds the result; the front keeps working until the queue fills.
module hough_segment_dedup_filter
  import hsdf_pkg::*;
#(
  parameter int MAX_KEPT   = MAX_KEPT_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] in_x_start,
  input  wire logic [COORD_BITS-1:0] in_y_start,
  input  wire logic [COORD_BITS-1:0] in_x_end,
  input  wire logic [COORD_BITS-1:0] in_y_end,
  input  wire logic                  in_frame_start,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_kept,
  output logic [2:0]                 out_verdict,
  output logic signed [SLOPE_W-1:0]  out_slope_q16,
  output logic [4:0]                 out_kept_count,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_AW-1:0]     cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  localparam int QW = SLOPE_W + ICPT_W + 4;

  cfg_t cfg_r;
  logic wr;

  logic               f_push, q_full, q_ne, q_pop;
  logic [SLOPE_W-1:0] f_slope;
  logic [ICPT_W-1:0]  f_icpt;
  logic [2:0]         f_verd;
  logic               f_frame;
  logic [QW-1:0]      q_rd;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_abs_slope   <= 20'd6554;
      cfg_r.min_angle_slope <= 20'd23853;
      cfg_r.dup_slope_tol   <= 20'd11796;
      cfg_r.dup_icpt_tol    <= 32'd3276800;
    end else if (wr) begin
      case (cfg_paddr)
        REG_MIN_ABS:   cfg_r.min_abs_slope   <= cfg_pwdata[19:0];
        REG_MIN_ANGLE: cfg_r.min_angle_slope <= cfg_pwdata[19:0];
        REG_DUP_SLOPE: cfg_r.dup_slope_tol   <= cfg_pwdata[19:0];
        REG_DUP_ICPT:  cfg_r.dup_icpt_tol    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_MIN_ABS:   cfg_prdata = 32'(cfg_r.min_abs_slope);
      REG_MIN_ANGLE: cfg_prdata = 32'(cfg_r.min_angle_slope);
      REG_DUP_SLOPE: cfg_prdata = 32'(cfg_r.dup_slope_tol);
      REG_DUP_ICPT:  cfg_prdata = cfg_r.dup_icpt_tol;
      default:       cfg_prdata = '0;
    endcase
  end

  hsdf_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x_start(in_x_start), .in_y_start(in_y_start),
    .in_x_end(in_x_end), .in_y_end(in_y_end), .in_frame_start(in_frame_start),
    .q_push(f_push), .q_full(q_full),
    .q_slope(f_slope), .q_icpt(f_icpt), .q_verdict(f_verd), .q_frame(f_frame)
  );

  hsdf_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(f_push),
    .wdata({f_slope, f_icpt, f_verd, f_frame}), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .rdata(q_rd)
  );

  hsdf_back #(.MAX_KEPT(MAX_KEPT)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_ne), .q_pop(q_pop),
    .q_slope(q_rd[QW-1 -: SLOPE_W]), .q_icpt(q_rd[ICPT_W+3 -: ICPT_W]),
    .q_verdict(q_rd[3:1]), .q_frame(q_rd[0]),
    .out_valid(out_valid), .out_stall(out_stall), .out_kept(out_kept),
    .out_verdict(out_verdict), .out_slope_q16(out_slope_q16),
    .out_kept_count(out_kept_count)
  );
endmodule
`default_nettype wire

// ===== sv/hsdf_checker.sv =====
`default_nettype none
module hsdf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_kept,
  input wire logic [2:0] out_verdict,
  input wire logic [4:0] out_kept_count
);
  import hsdf_pkg::*;

  a_kept_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kept == (out_verdict == VERDICT_KEPT))) else $error("kept flag");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict <= VERDICT_FULL)) else $error("verdict code");

  a_kept_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kept) |-> (out_kept_count != 5'd0)) else $error("count after keep");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_verdict))) else $error("hold");
endmodule

bind hough_segment_dedup_filter hsdf_checker u_hsdf_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_kept(out_kept), .out_verdict(out_verdict), .out_kept_count(out_kept_count)
);
`default_nettype wire
